/* rtl/buddy_block_allocator_top_macros.svh */
// Assertion macros used by the allocator datapath.
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTH
`define BBA_ASSERT_HOLD(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define BBA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define BBA_ASSERT_HOLD(lbl, clk, rst, expr)
`define BBA_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/bba_pkg.sv */
// Shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
package bba_pkg;

  localparam int unsigned HEAP_BYTES_DEF      = 1048576;
  localparam int unsigned MIN_BLOCK_BYTES_DEF = 4096;

  localparam int REQ_W    = 32;
  localparam int STATUS_W = 2;
  localparam int OFFSET_W = 20;
  localparam int FREE_W   = 21;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT   = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // read address select
  localparam logic [2:0] RD_IDX    = 3'd0;
  localparam logic [2:0] RD_LEFT   = 3'd1;
  localparam logic [2:0] RD_RIGHT  = 3'd2;
  localparam logic [2:0] RD_SIB    = 3'd3;
  localparam logic [2:0] RD_BUDDY  = 3'd4;
  localparam logic [2:0] RD_PARENT = 3'd5;

  // write address select
  localparam logic [1:0] WA_CLR    = 2'd0;
  localparam logic [1:0] WA_IDX    = 2'd1;
  localparam logic [1:0] WA_PARENT = 2'd2;

  // tree cursor moves
  localparam logic [1:0] IX_HOLD   = 2'd0;
  localparam logic [1:0] IX_LEFT   = 2'd1;
  localparam logic [1:0] IX_SIB    = 2'd2;
  localparam logic [1:0] IX_PARENT = 2'd3;

  typedef struct packed {
    logic       clr_step;
    logic       load;
    logic       depth_step;
    logic [2:0] rd_sel;
    logic       we;
    logic       wdata;
    logic [1:0] wa_sel;
    logic [1:0] idx_op;
    logic       keep_off;
    logic       lb_latch;
    logic       credit_node;
    logic       credit_root;
    logic       cnt_sub;
    logic       cnt_add;
    logic       stat_nospace;
    logic       stat_reject;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic opc;
    logic too_big;
    logic size_done;
    logic bad;
    logic lvl_zero;
    logic busy;
    logic lb;
    logic is_root;
    logic is_left;
    logic credited;
    logic out_free;
  } sts_t;

endpackage

/* rtl/bba_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module bba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 511
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bba_ctrl.sv */
// Controller state machine: tree clear, search, climb and result sequencing.
`timescale 1ns / 1ps
module bba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SIZE  = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_CHKL  = 4'd4;
  localparam logic [3:0] S_CHKR  = 4'd5;
  localparam logic [3:0] S_FAIL  = 4'd6;
  localparam logic [3:0] S_UP    = 4'd7;
  localparam logic [3:0] S_FCHK  = 4'd8;
  localparam logic [3:0] S_FNODE = 4'd9;
  localparam logic [3:0] S_FBUD  = 4'd10;
  localparam logic [3:0] S_FADD  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.rd_sel = bba_pkg::RD_IDX;
    cmd.wa_sel = bba_pkg::WA_IDX;
    cmd.idx_op = bba_pkg::IX_HOLD;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        cmd.we       = 1'b1;
        cmd.wa_sel   = bba_pkg::WA_CLR;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = (sts.opc == bba_pkg::OP_FREE) ? S_FCHK : S_SIZE;
        end
      end
      S_SIZE: begin
        priority if (sts.too_big) begin
          cmd.stat_nospace = 1'b1;
          state_next       = S_DONE;
        end else if (sts.size_done) begin
          cmd.rd_sel = bba_pkg::RD_IDX;
          state_next = S_CHK;
        end else begin
          cmd.depth_step = 1'b1;
        end
      end
      S_CHK: begin
        priority if (sts.lvl_zero) begin
          if (sts.busy) begin
            state_next = S_FAIL;
          end else begin
            cmd.we       = 1'b1;
            cmd.wdata    = 1'b1;
            cmd.wa_sel   = bba_pkg::WA_IDX;
            cmd.keep_off = 1'b1;
            state_next   = S_UP;
          end
        end else if (!sts.busy) begin
          cmd.rd_sel = bba_pkg::RD_LEFT;
          cmd.idx_op = bba_pkg::IX_LEFT;
        end else begin
          // busy node: look at both children before descending
          cmd.rd_sel = bba_pkg::RD_LEFT;
          state_next = S_CHKL;
        end
      end
      S_CHKL: begin
        cmd.lb_latch = 1'b1;
        cmd.rd_sel   = bba_pkg::RD_RIGHT;
        state_next   = S_CHKR;
      end
      S_CHKR: begin
        if (sts.lb || sts.busy) begin
          cmd.rd_sel = bba_pkg::RD_LEFT;
          cmd.idx_op = bba_pkg::IX_LEFT;
          state_next = S_CHK;
        end else begin
          state_next = S_FAIL;
        end
      end
      S_FAIL: begin
        priority if (sts.is_root) begin
          cmd.stat_nospace = 1'b1;
          state_next       = S_DONE;
        end else if (sts.is_left) begin
          cmd.rd_sel = bba_pkg::RD_SIB;
          cmd.idx_op = bba_pkg::IX_SIB;
          state_next = S_CHK;
        end else begin
          cmd.idx_op = bba_pkg::IX_PARENT;
        end
      end
      S_UP: begin
        if (sts.is_root) begin
          cmd.cnt_sub = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.we     = 1'b1;
          cmd.wdata  = 1'b1;
          cmd.wa_sel = bba_pkg::WA_PARENT;
          cmd.idx_op = bba_pkg::IX_PARENT;
        end
      end
      S_FCHK: begin
        if (sts.bad) begin
          cmd.stat_reject = 1'b1;
          state_next      = S_DONE;
        end else begin
          cmd.rd_sel = bba_pkg::RD_IDX;
          state_next = S_FNODE;
        end
      end
      S_FNODE: begin
        cmd.we     = 1'b1;
        cmd.wa_sel = bba_pkg::WA_IDX;
        if (sts.is_root) begin
          cmd.credit_root = sts.busy && !sts.credited;
          state_next      = S_FADD;
        end else begin
          cmd.credit_node = sts.busy && !sts.credited;
          cmd.rd_sel      = bba_pkg::RD_BUDDY;
          state_next      = S_FBUD;
        end
      end
      S_FBUD: begin
        if (sts.busy) begin
          state_next = S_FADD;
        end else begin
          cmd.rd_sel = bba_pkg::RD_PARENT;
          cmd.idx_op = bba_pkg::IX_PARENT;
          state_next = S_FNODE;
        end
      end
      S_FADD: begin
        cmd.cnt_add = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/bba_dp.sv */
// Datapath: busy-bit tree memory, tree cursor, free count and result registers.
`timescale 1ns / 1ps
module bba_dp #(
  parameter int unsigned HEAP_BYTES      = bba_pkg::HEAP_BYTES_DEF,
  parameter int unsigned MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bba_pkg::cmd_t                 cmd,
  output bba_pkg::sts_t                 sts,
  input  logic                          opcode,
  input  logic [bba_pkg::REQ_W-1:0]     request_size,
  input  logic [bba_pkg::REQ_W-1:0]     free_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bba_pkg::STATUS_W-1:0]  status,
  output logic [bba_pkg::OFFSET_W-1:0]  block_offset,
  output logic [bba_pkg::FREE_W-1:0]    free_bytes
);

  localparam int LOG_HEAP = $clog2(HEAP_BYTES);
  localparam int LOG_MIN  = $clog2(MIN_BLOCK_BYTES);
  localparam int LEAFD    = LOG_HEAP - LOG_MIN;
  localparam int LEAVES   = HEAP_BYTES / MIN_BLOCK_BYTES;
  localparam int NODES    = 2 * LEAVES - 1;
  localparam int IW       = $clog2(NODES);
  localparam int HW       = LOG_HEAP + 1;
  localparam int AW       = LOG_HEAP;
  localparam int DW       = $clog2(LEAFD + 1);

  localparam logic [HW-1:0] HEAP_V = HW'(HEAP_BYTES);
  localparam logic [HW-1:0] MIN_V  = HW'(MIN_BLOCK_BYTES);

  logic [bba_pkg::REQ_W-1:0] want;
  logic [HW-1:0]             spanreq;
  logic [DW-1:0]             dreq;
  logic [IW-1:0]             idx;
  logic [DW-1:0]             cur_d;
  logic [AW-1:0]             base;
  logic [HW-1:0]             nspan;
  logic                      lb;
  logic                      credited;
  logic [HW-1:0]             credit;
  logic [HW-1:0]             count;
  logic                      bad;
  logic [IW-1:0]             clr;
  logic [bba_pkg::STATUS_W-1:0] res_status;
  logic [AW-1:0]             res_off;
  logic [bba_pkg::STATUS_W-1:0] out_status;
  logic [AW-1:0]             out_off;
  logic [HW-1:0]             out_cnt;

  logic [IW-1:0] left_idx, right_idx, sib_idx, parent_idx, buddy_idx, leaf_idx;
  logic [IW-1:0] raddr, waddr;
  logic          rbit;
  logic [HW:0]   sum;
  logic          out_free;
  logic [AW+bba_pkg::OFFSET_W-1:0] off_ext;
  logic [HW+bba_pkg::FREE_W-1:0]   cnt_ext;

  assign left_idx   = IW'({1'b0, idx, 1'b1});
  assign right_idx  = IW'(({1'b0, idx} << 1) + (IW + 1)'(2));
  assign sib_idx    = idx + IW'(1);
  assign parent_idx = IW'((idx - IW'(1)) >> 1);
  assign buddy_idx  = idx[0] ? idx + IW'(1) : idx - IW'(1);
  assign leaf_idx   = IW'((free_offset >> LOG_MIN) + 32'(LEAVES - 1));

  always_comb begin
    unique case (cmd.rd_sel)
      bba_pkg::RD_LEFT:   raddr = left_idx;
      bba_pkg::RD_RIGHT:  raddr = right_idx;
      bba_pkg::RD_SIB:    raddr = sib_idx;
      bba_pkg::RD_BUDDY:  raddr = buddy_idx;
      bba_pkg::RD_PARENT: raddr = parent_idx;
      default:            raddr = idx;
    endcase
  end

  always_comb begin
    unique case (cmd.wa_sel)
      bba_pkg::WA_CLR:    waddr = clr;
      bba_pkg::WA_PARENT: waddr = parent_idx;
      default:            waddr = idx;
    endcase
  end

  bba_ram #(
    .WIDTH(1),
    .DEPTH(NODES)
  ) u_tree (
    .clk  (clk),
    .we   (cmd.we),
    .waddr(waddr),
    .wdata(cmd.wdata),
    .raddr(raddr),
    .rdata(rbit)
  );

  assign sum      = {1'b0, count} + {1'b0, credit};
  assign out_free = !out_valid || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      count     <= HEAP_V;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr <= clr + IW'(1);
      end
      if (cmd.cnt_sub) begin
        count <= (count >= spanreq) ? count - spanreq : '0;
      end else if (cmd.cnt_add) begin
        count <= (sum > {1'b0, HEAP_V}) ? HEAP_V : sum[HW-1:0];
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers of the current item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      want       <= request_size;
      spanreq    <= HEAP_V;
      dreq       <= '0;
      credit     <= '0;
      credited   <= 1'b0;
      res_status <= bba_pkg::ST_DONE;
      res_off    <= '0;
      base       <= '0;
      bad        <= (free_offset[LOG_MIN-1:0] != '0) ||
                    (free_offset >= 32'(HEAP_BYTES));
      if (opcode == bba_pkg::OP_FREE) begin
        idx   <= leaf_idx;
        nspan <= MIN_V;
        cur_d <= DW'(LEAFD);
      end else begin
        idx   <= '0;
        nspan <= HEAP_V;
        cur_d <= '0;
      end
    end else begin
      if (cmd.depth_step) begin
        spanreq <= spanreq >> 1;
        dreq    <= dreq + DW'(1);
      end
      unique case (cmd.idx_op)
        bba_pkg::IX_LEFT: begin
          idx   <= left_idx;
          cur_d <= cur_d + DW'(1);
          nspan <= nspan >> 1;
        end
        bba_pkg::IX_SIB: begin
          idx  <= sib_idx;
          base <= base + AW'(nspan);
        end
        bba_pkg::IX_PARENT: begin
          idx   <= parent_idx;
          cur_d <= cur_d - DW'(1);
          base  <= base - AW'(nspan);
          nspan <= nspan << 1;
        end
        default: begin
        end
      endcase
      if (cmd.keep_off) begin
        res_off <= base;
      end
      if (cmd.credit_node) begin
        credit   <= nspan;
        credited <= 1'b1;
      end else if (cmd.credit_root) begin
        credit <= HEAP_V;
      end
      if (cmd.stat_nospace) begin
        res_status <= bba_pkg::ST_NO_SPACE;
      end else if (cmd.stat_reject) begin
        res_status <= bba_pkg::ST_REJECT;
      end
    end
    if (cmd.lb_latch) begin
      lb <= rbit;
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_off    <= res_off;
      out_cnt    <= count;
    end
  end

  always_comb begin
    sts           = '0;
    sts.clr_last  = (clr == IW'(NODES - 1));
    sts.opc       = opcode;
    sts.too_big   = {1'b0, want} > 33'(HEAP_BYTES);
    sts.size_done = (dreq == DW'(LEAFD)) || ({1'b0, want} > 33'(spanreq >> 1));
    sts.bad       = bad;
    sts.lvl_zero  = (cur_d == dreq);
    sts.busy      = rbit;
    sts.lb        = lb;
    sts.is_root   = (idx == '0);
    sts.is_left   = idx[0];
    sts.credited  = credited;
    sts.out_free  = out_free;
  end

  assign off_ext      = {bba_pkg::OFFSET_W'(0), out_off};
  assign cnt_ext      = {bba_pkg::FREE_W'(0), out_cnt};
  assign status       = out_status;
  assign block_offset = off_ext[bba_pkg::OFFSET_W-1:0];
  assign free_bytes   = cnt_ext[bba_pkg::FREE_W-1:0];

`include "buddy_block_allocator_top_macros.svh"

  `BBA_ASSERT_HOLD(a_count_bound, clk, rst, count <= HEAP_V)
  `BBA_ASSERT_IMPLY(a_parent_not_root, clk, rst, cmd.we && (cmd.wa_sel == bba_pkg::WA_PARENT), idx != '0)
  `BBA_ASSERT_IMPLY(a_load_when_free, clk, rst, cmd.out_load, out_free)

endmodule

/* rtl/buddy_block_allocator_top.sv */
// Sequence, accept to result: alloc sizes the request, descends clear nodes, checks both children
// of each busy node, backs out of failed levels, then marks the block and its ancestors busy;
// all tree reads go through the single tree read port.
// Free walks up from the leaf, clearing nodes while the buddy is free, and credits the freed span;
// reject and oversize go straight to the result. One item at a time, result may wait in its register.
// Reset: busy tree cleared by a pass over all 2 * HEAP_BYTES / MIN_BLOCK_BYTES - 1 nodes, no intake.
`timescale 1ns / 1ps
module buddy_block_allocator_top #(
  parameter int unsigned HEAP_BYTES      = bba_pkg::HEAP_BYTES_DEF,
  parameter int unsigned MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [bba_pkg::REQ_W-1:0]     request_size,
  input  logic [bba_pkg::REQ_W-1:0]     free_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bba_pkg::STATUS_W-1:0]  status,
  output logic [bba_pkg::OFFSET_W-1:0]  block_offset,
  output logic [bba_pkg::FREE_W-1:0]    free_bytes
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  bba_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  bba_dp #(
    .HEAP_BYTES     (HEAP_BYTES),
    .MIN_BLOCK_BYTES(MIN_BLOCK_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .opcode      (opcode),
    .request_size(request_size),
    .free_offset (free_offset),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .block_offset(block_offset),
    .free_bytes  (free_bytes)
  );

endmodule
